### hdl/tkz_pkg.sv
package tkz_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int MAX_RES     = 3;

    localparam logic [62:0] VAL_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // register byte addresses
    localparam logic [2:0] ADDR_START_LINE = 3'd0;
    localparam logic [2:0] ADDR_NL_TOKEN   = 3'd4;

    // event codes
    localparam logic [1:0] EV_TEXT = 2'd0;
    localparam logic [1:0] EV_DONE = 2'd1;
    localparam logic [1:0] EV_END  = 2'd2;

    // token classes
    localparam logic [1:0] TC_IDENT   = 2'd0;
    localparam logic [1:0] TC_LITERAL = 2'd1;
    localparam logic [1:0] TC_SYMBOL  = 2'd2;

    // literal classes
    localparam logic [1:0] LC_INT    = 2'd0;
    localparam logic [1:0] LC_REAL   = 2'd1;
    localparam logic [1:0] LC_STRING = 2'd2;
    localparam logic [1:0] LC_ERROR  = 2'd3;

    // symbol codes
    localparam logic [3:0] SC_LBRACE = 4'd0;
    localparam logic [3:0] SC_RBRACE = 4'd1;
    localparam logic [3:0] SC_LPAREN = 4'd2;
    localparam logic [3:0] SC_RPAREN = 4'd3;
    localparam logic [3:0] SC_EQUAL  = 4'd4;
    localparam logic [3:0] SC_PLUS   = 4'd5;
    localparam logic [3:0] SC_MINUS  = 4'd6;
    localparam logic [3:0] SC_SEMI   = 4'd7;
    localparam logic [3:0] SC_COLON  = 4'd8;
    localparam logic [3:0] SC_CARET  = 4'd9;
    localparam logic [3:0] SC_DOT    = 4'd10;
    localparam logic [3:0] SC_LF     = 4'd11;
    localparam logic [3:0] SC_ERROR  = 4'd12;

    // number part flag bits
    localparam int F_INT    = 0;
    localparam int F_FRAC   = 1;
    localparam int F_EXP    = 2;
    localparam int F_BADOCT = 3;
    localparam int F_ERR    = 4;
    localparam int F_HEXDIG = 5;

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]             event_res;
        logic [7:0]             raw_byte;
        logic [7:0]             value_byte;
        logic                   value_byte_valid;
        logic [1:0]             token_class;
        logic [1:0]             literal_class;
        logic [3:0]             symbol_code;
        logic [31:0]            token_line;
        logic [LENGTH_BITS-1:0] token_length;
        logic [62:0]            int_value;
        logic                   last;
    } out_t;

    typedef struct packed {
        logic [1:0]         count;
        out_t [MAX_RES-1:0] item;
    } res_bundle_t;

endpackage

### hdl/config_text_tokenizer.sv
// Configuration-text tokenizer. Takes one text byte per request (or an end-of-input
// request) and gives up to three results per request: echoed token bytes, token
// completions and the end-of-input marker. A request is taken in every cycle while
// the result queue (eight entries) has room for three more results; results leave
// at one per cycle while m_ready is high, so the sustained rate is one request
// per cycle when each request gives one result, and set by the output port when
// requests give more. start_line (0x0) and newline_as_token (0x4) sit on the APB
// port; write them only while no request is in flight.
module config_text_tokenizer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tkz_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tkz_pkg::out_t m_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [31:0]          start_val_reg;
    logic                 nl_reg;
    logic                 wr_en, line_load, step;
    tkz_pkg::res_bundle_t res;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign line_load = wr_en && (paddr == tkz_pkg::ADDR_START_LINE);
    assign step      = s_valid && s_ready;

    always_comb begin
        case (paddr)
            tkz_pkg::ADDR_START_LINE: prdata = start_val_reg;
            tkz_pkg::ADDR_NL_TOKEN:   prdata = {31'd0, nl_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_val_reg  <= 32'd1;
            nl_reg         <= 1'b0;
        end else begin
            if (line_load) start_val_reg <= pwdata;
            if (wr_en && paddr == tkz_pkg::ADDR_NL_TOKEN) nl_reg <= pwdata[0];
        end
    end

    tkz_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .in_data    (s_data),
        .start_line (start_val_reg),
        .nl_token   (nl_reg),
        .line_load  (line_load),
        .line_value (pwdata),
        .res        (res)
    );

    tkz_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_data (res),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hdl/tkz_core.sv
module tkz_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  tkz_pkg::in_t         in_data,
    input  logic [31:0]          start_line,
    input  logic                 nl_token,
    input  logic                 line_load,
    input  logic [31:0]          line_value,
    output tkz_pkg::res_bundle_t res
);

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_DOT, M_NUMBER, M_STRING, M_ESC
    } mode_t;

    typedef enum logic [2:0] {
        P_DEC, P_OCT, P_HEX, P_FRAC, P_EXP, P_EXPS, P_ZERO
    } phase_t;

    mode_t                          mode_reg, mode_next;
    phase_t                         phase_reg, phase_next;
    logic [5:0]                     flags_reg, flags_next;
    logic [31:0]                    line_reg, line_next;
    logic [31:0]                    tok_line_reg, tok_line_next;
    logic [31:0]                    pend_reg, pend_next;
    logic [tkz_pkg::LENGTH_BITS-1:0] len_reg, len_next;
    logic [62:0]                    acc_reg, acc_next;

    function automatic tkz_pkg::out_t mk(
        input logic [1:0] ev, input logic [7:0] raw, input logic [7:0] val,
        input logic vv, input logic [1:0] tc, input logic [1:0] lcl,
        input logic [3:0] sc, input logic [62:0] iv, input logic [31:0] tl,
        input logic [tkz_pkg::LENGTH_BITS-1:0] len);
        tkz_pkg::out_t r;
        r.event_res        = ev;
        r.raw_byte         = raw;
        r.value_byte       = val;
        r.value_byte_valid = vv;
        r.token_class      = tc;
        r.literal_class    = lcl;
        r.symbol_code      = sc;
        r.token_line       = (ev == tkz_pkg::EV_END) ? 32'd0 : tl;
        r.token_length     = (ev == tkz_pkg::EV_END) ? '0 : len;
        r.int_value        = iv;
        r.last             = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // multiply-accumulate by base 8, 10 or 16, clamp at the largest value
    function automatic logic [62:0] acc_step(input logic [62:0] a, input logic [1:0] sel,
                                             input logic [3:0] d);
        logic [66:0] p;
        case (sel)
            2'd0:    p = ({4'b0, a} << 3) + ({4'b0, a} << 1);
            2'd1:    p = {4'b0, a} << 3;
            default: p = {4'b0, a} << 4;
        endcase
        p = p + {63'b0, d};
        return (p > {4'b0, tkz_pkg::VAL_MAX}) ? tkz_pkg::VAL_MAX : p[62:0];
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if (c >= "0" && c <= "9") begin
            t = c - 8'd48;
        end else if (c >= "a" && c <= "f") begin
            t = c - 8'd87;
        end else if (c >= "A" && c <= "F") begin
            t = c - 8'd55;
        end else begin
            t = 8'd16;
        end
        return t[4:0];
    endfunction

    function automatic logic [3:0] sym_of(input logic [7:0] c);
        case (c)
            "{":     return tkz_pkg::SC_LBRACE;
            "}":     return tkz_pkg::SC_RBRACE;
            "(":     return tkz_pkg::SC_LPAREN;
            ")":     return tkz_pkg::SC_RPAREN;
            "=":     return tkz_pkg::SC_EQUAL;
            "+":     return tkz_pkg::SC_PLUS;
            "-":     return tkz_pkg::SC_MINUS;
            ";":     return tkz_pkg::SC_SEMI;
            ":":     return tkz_pkg::SC_COLON;
            "^":     return tkz_pkg::SC_CARET;
            default: return tkz_pkg::SC_ERROR;
        endcase
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            "n":     return 8'd10;
            "t":     return 8'd9;
            "v":     return 8'd11;
            "b":     return 8'd8;
            "r":     return 8'd13;
            "f":     return 8'd12;
            default: return c;
        endcase
    endfunction

    logic [7:0] ch;
    logic       is_dig, is_alpha, is_word, is_space, is_ee, is_x;

    assign ch       = in_data.in_byte;
    assign is_dig   = (ch >= "0") && (ch <= "9");
    assign is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    assign is_word  = is_alpha || is_dig || (ch == "_");
    assign is_space = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
    assign is_ee    = (ch == "e") || (ch == "E");
    assign is_x     = (ch == "x") || (ch == "X");

    always_comb begin
        tkz_pkg::out_t [tkz_pkg::MAX_RES-1:0] item;
        logic [1:0] n;
        logic       do_idle, do_finish, ok;
        logic [1:0] lcl;
        phase_t     eph;
        logic [3:0] dval;
        logic [4:0] hv;

        mode_next     = mode_reg;
        phase_next    = phase_reg;
        flags_next    = flags_reg;
        line_next     = line_reg;
        tok_line_next = tok_line_reg;
        pend_next     = pend_reg;
        len_next      = len_reg;
        acc_next      = acc_reg;
        item          = '0;
        n             = 2'd0;
        do_idle       = 1'b0;
        do_finish     = 1'b0;
        ok            = 1'b1;
        lcl           = tkz_pkg::LC_ERROR;
        eph           = phase_reg;
        dval          = ch[3:0];
        hv            = hex_val(ch);

        if (in_data.op) begin
            case (mode_reg)
                M_IDENT: begin
                    item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_IDENT,
                                 2'd0, 4'd0, 63'd0, tok_line_next, len_next);
                    n = n + 2'd1;
                end
                M_DOT: begin
                    item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_SYMBOL,
                                 2'd0, tkz_pkg::SC_DOT, 63'd0, tok_line_next, len_next);
                    n = n + 2'd1;
                end
                M_NUMBER: do_finish = 1'b1;
                M_STRING, M_ESC: begin
                    item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_LITERAL,
                                 tkz_pkg::LC_ERROR, 4'd0, 63'd0, tok_line_next, len_next);
                    n = n + 2'd1;
                end
                default: ;
            endcase
        end else begin
            case (mode_reg)
                M_COMMENT: begin
                    if (ch == 8'd10) do_idle = 1'b1;
                end
                M_IDENT: begin
                    if (is_word) begin
                        if (len_next != tkz_pkg::LEN_MAX) len_next = len_next + 1'b1;
                        item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0,
                                     63'd0, tok_line_next, len_next);
                        n = n + 2'd1;
                    end else begin
                        item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_IDENT,
                                     2'd0, 4'd0, 63'd0, tok_line_next, len_next);
                        n = n + 2'd1;
                        line_next = sat_add(line_next, pend_next);
                        pend_next = 32'd0;
                        do_idle   = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_dig) begin
                        mode_next  = M_NUMBER;
                        phase_next = P_FRAC;
                        flags_next = 6'd0;
                        flags_next[tkz_pkg::F_FRAC] = 1'b1;
                        if (len_next != tkz_pkg::LEN_MAX) len_next = len_next + 1'b1;
                        item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0,
                                     63'd0, tok_line_next, len_next);
                        n = n + 2'd1;
                    end else begin
                        item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_SYMBOL,
                                     2'd0, tkz_pkg::SC_DOT, 63'd0, tok_line_next, len_next);
                        n = n + 2'd1;
                        line_next = sat_add(line_next, pend_next);
                        pend_next = 32'd0;
                        do_idle   = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (phase_reg == P_ZERO) begin
                        if (is_dig) eph = P_OCT;
                        else if (is_x) eph = P_HEX;
                        else eph = P_DEC;
                    end
                    phase_next = eph;
                    if (phase_reg == P_ZERO && is_x) begin
                        ok = 1'b1;
                    end else begin
                        case (eph)
                            P_DEC, P_OCT: begin
                                if (is_dig) begin
                                    if (eph == P_DEC) acc_next = acc_step(acc_next, 2'd0, dval);
                                    else if (dval >= 4'd8) flags_next[tkz_pkg::F_BADOCT] = 1'b1;
                                    else acc_next = acc_step(acc_next, 2'd1, dval);
                                end else if (ch == ".") begin
                                    phase_next = P_FRAC;
                                end else if (is_ee) begin
                                    phase_next = P_EXP;
                                end else begin
                                    ok = 1'b0;
                                end
                            end
                            P_HEX: begin
                                if (hv[4]) begin
                                    ok = 1'b0;
                                end else begin
                                    acc_next = acc_step(acc_next, 2'd2, hv[3:0]);
                                    flags_next[tkz_pkg::F_HEXDIG] = 1'b1;
                                end
                            end
                            P_FRAC: begin
                                if (is_dig) begin
                                    flags_next[tkz_pkg::F_FRAC] = 1'b1;
                                end else if (is_ee && (flags_next[tkz_pkg::F_INT] ||
                                                       flags_next[tkz_pkg::F_FRAC])) begin
                                    phase_next = P_EXP;
                                end else begin
                                    if (!(flags_next[tkz_pkg::F_INT] || flags_next[tkz_pkg::F_FRAC]))
                                        flags_next[tkz_pkg::F_ERR] = 1'b1;
                                    ok = 1'b0;
                                end
                            end
                            P_EXP, P_EXPS: begin
                                if (is_dig) begin
                                    flags_next[tkz_pkg::F_EXP] = 1'b1;
                                end else if (eph == P_EXP && !flags_next[tkz_pkg::F_EXP] &&
                                             (ch == "+" || ch == "-")) begin
                                    phase_next = P_EXPS;
                                end else begin
                                    if (!flags_next[tkz_pkg::F_EXP])
                                        flags_next[tkz_pkg::F_ERR] = 1'b1;
                                    ok = 1'b0;
                                end
                            end
                            default: ok = 1'b0;
                        endcase
                    end
                    if (ok) begin
                        if (len_next != tkz_pkg::LEN_MAX) len_next = len_next + 1'b1;
                        item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0,
                                     63'd0, tok_line_next, len_next);
                        n = n + 2'd1;
                    end else begin
                        do_finish = 1'b1;
                        do_idle   = 1'b1;
                    end
                end
                M_STRING: begin
                    if (ch == 8'd10) begin
                        pend_next = sat_add(pend_next, 32'd1);
                        item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_LITERAL,
                                     tkz_pkg::LC_ERROR, 4'd0, 63'd0, tok_line_next, len_next);
                        n = n + 2'd1;
                        line_next = sat_add(line_next, pend_next);
                        pend_next = 32'd0;
                        mode_next = M_IDLE;
                    end else begin
                        if (len_next != tkz_pkg::LEN_MAX) len_next = len_next + 1'b1;
                        if (ch == "\"") begin
                            item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0,
                                         63'd0, tok_line_next, len_next);
                            n = n + 2'd1;
                            item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0,
                                         tkz_pkg::TC_LITERAL, tkz_pkg::LC_STRING, 4'd0, 63'd0,
                                         tok_line_next, len_next);
                            n = n + 2'd1;
                            line_next = sat_add(line_next, pend_next);
                            pend_next = 32'd0;
                            mode_next = M_IDLE;
                        end else if (ch == "\\") begin
                            item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0,
                                         63'd0, tok_line_next, len_next);
                            n = n + 2'd1;
                            mode_next = M_ESC;
                        end else begin
                            item[n] = mk(tkz_pkg::EV_TEXT, ch, ch, 1'b1, 2'd0, 2'd0, 4'd0,
                                         63'd0, tok_line_next, len_next);
                            n = n + 2'd1;
                        end
                    end
                end
                M_ESC: begin
                    if (len_next != tkz_pkg::LEN_MAX) len_next = len_next + 1'b1;
                    if (ch == 8'd10) begin
                        pend_next = sat_add(pend_next, 32'd1);
                        item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0,
                                     63'd0, tok_line_next, len_next);
                    end else begin
                        item[n] = mk(tkz_pkg::EV_TEXT, ch, unescape(ch), 1'b1, 2'd0, 2'd0,
                                     4'd0, 63'd0, tok_line_next, len_next);
                    end
                    n = n + 2'd1;
                    mode_next = M_STRING;
                end
                default: do_idle = 1'b1;
            endcase
        end

        // close a number with the phase and flags it ended in
        if (do_finish) begin
            case (phase_next)
                P_FRAC, P_EXP, P_EXPS: begin
                    if (flags_next[tkz_pkg::F_ERR] ||
                        (phase_next != P_FRAC && !flags_next[tkz_pkg::F_EXP]) ||
                        !(flags_next[tkz_pkg::F_INT] || flags_next[tkz_pkg::F_FRAC]))
                        lcl = tkz_pkg::LC_ERROR;
                    else
                        lcl = tkz_pkg::LC_REAL;
                end
                P_DEC, P_ZERO: lcl = tkz_pkg::LC_INT;
                P_OCT: lcl = flags_next[tkz_pkg::F_BADOCT] ? tkz_pkg::LC_ERROR : tkz_pkg::LC_INT;
                P_HEX: lcl = flags_next[tkz_pkg::F_HEXDIG] ? tkz_pkg::LC_INT : tkz_pkg::LC_ERROR;
                default: lcl = tkz_pkg::LC_ERROR;
            endcase
            item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_LITERAL, lcl, 4'd0,
                         (lcl == tkz_pkg::LC_INT) ? acc_next : 63'd0, tok_line_next, len_next);
            n = n + 2'd1;
            line_next = sat_add(line_next, pend_next);
            pend_next = 32'd0;
            mode_next = M_IDLE;
        end

        // handle the byte afresh from the idle state
        if (do_idle) begin
            mode_next = M_IDLE;
            if (ch == 8'd10) begin
                line_next = sat_add(line_next, 32'd1);
                if (nl_token) begin
                    tok_line_next = line_next;
                    len_next      = '0;
                    acc_next      = '0;
                    flags_next    = '0;
                    phase_next    = P_DEC;
                    pend_next     = 32'd0;
                    len_next      = len_next + 1'b1;
                    item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0, 63'd0,
                                 tok_line_next, len_next);
                    n = n + 2'd1;
                    item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_SYMBOL,
                                 2'd0, tkz_pkg::SC_LF, 63'd0, tok_line_next, len_next);
                    n = n + 2'd1;
                end
            end else if (is_space) begin
                mode_next = M_IDLE;
            end else if (ch == "#") begin
                mode_next = M_COMMENT;
            end else begin
                tok_line_next = line_next;
                len_next      = '0;
                acc_next      = '0;
                flags_next    = '0;
                phase_next    = P_DEC;
                pend_next     = 32'd0;
                len_next      = len_next + 1'b1;
                item[n] = mk(tkz_pkg::EV_TEXT, ch, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0, 63'd0,
                             tok_line_next, len_next);
                n = n + 2'd1;
                if (is_alpha || ch == "_") begin
                    mode_next = M_IDENT;
                end else if (is_dig) begin
                    mode_next  = M_NUMBER;
                    flags_next[tkz_pkg::F_INT] = 1'b1;
                    phase_next = (ch == "0") ? P_ZERO : P_DEC;
                    acc_next   = {59'd0, dval};
                end else if (ch == ".") begin
                    mode_next = M_DOT;
                end else if (ch == "\"") begin
                    mode_next = M_STRING;
                end else begin
                    item[n] = mk(tkz_pkg::EV_DONE, 8'd0, 8'd0, 1'b0, tkz_pkg::TC_SYMBOL,
                                 2'd0, sym_of(ch), 63'd0, tok_line_next, len_next);
                    n = n + 2'd1;
                end
            end
        end

        if (in_data.op) begin
            item[n] = mk(tkz_pkg::EV_END, 8'd0, 8'd0, 1'b0, 2'd0, 2'd0, 4'd0, 63'd0,
                         tok_line_next, len_next);
            n = n + 2'd1;
            mode_next = M_IDLE;
            line_next = start_line;
            pend_next = 32'd0;
        end

        if (n != 2'd0) item[n - 2'd1].last = 1'b1;
        res.count = n;
        res.item  = item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            phase_reg    <= P_DEC;
            flags_reg    <= '0;
            line_reg     <= 32'd1;
            tok_line_reg <= '0;
            pend_reg     <= '0;
            len_reg      <= '0;
            acc_reg      <= '0;
        end else if (line_load) begin
            line_reg <= line_value;
        end else if (step) begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            flags_reg    <= flags_next;
            line_reg     <= line_next;
            tok_line_reg <= tok_line_next;
            pend_reg     <= pend_next;
            len_reg      <= len_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

### hdl/tkz_queue.sv
module tkz_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tkz_pkg::res_bundle_t push_data,
    output logic                 space,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tkz_pkg::out_t        m_data
);

    localparam int CW = tkz_pkg::QUEUE_AW + 1;

    tkz_pkg::out_t             mem_reg [tkz_pkg::QUEUE_DEPTH];
    logic [tkz_pkg::QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0]             count_reg, count_next;
    logic                      pop;
    logic [1:0]                n_in;

    assign n_in    = push ? push_data.count : 2'd0;
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_reg];
    // room for the most results one request can give
    assign space   = (count_reg <= CW'(tkz_pkg::QUEUE_DEPTH - tkz_pkg::MAX_RES));
    assign count_next = count_reg + CW'(n_in) - CW'(pop);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < tkz_pkg::MAX_RES; i++) begin
            if (i < int'(n_in)) begin
                mem_reg[wr_reg + tkz_pkg::QUEUE_AW'(i)] <= push_data.item[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_reg + tkz_pkg::QUEUE_AW'(n_in);
            rd_reg    <= rd_reg + tkz_pkg::QUEUE_AW'(pop);
            count_reg <= count_next;
        end
    end

endmodule
